@@ hdl/dpse_pkg.sv @@
// ----------------------------------------------------------------------------
// Delta patch stream encoder package
// Shared constants, configuration record and the token format that the front
// end hands to the byte serialiser.
// ----------------------------------------------------------------------------
package dpse_pkg;

   localparam int unsigned EQUAL_HOLD_DEPTH_DEF = 4;
   localparam int unsigned QUEUE_DEPTH          = 4;

   localparam logic [2:0] MODE_FLUSH = 3'd0;
   localparam logic [2:0] MODE_MOD   = 3'd1;
   localparam logic [2:0] MODE_INS   = 3'd2;
   localparam logic [2:0] MODE_DEL   = 3'd3;
   localparam logic [2:0] MODE_BKT   = 3'd4;
   localparam logic [2:0] MODE_EQL   = 3'd5;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ESC = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MOD = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_INS = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEL = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_EQL = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_BKT = 3'd5;

   localparam logic [7:0] ESC_CODE_RST = 8'd167;
   localparam logic [7:0] MOD_CODE_RST = 8'd166;
   localparam logic [7:0] INS_CODE_RST = 8'd165;
   localparam logic [7:0] DEL_CODE_RST = 8'd164;
   localparam logic [7:0] EQL_CODE_RST = 8'd163;
   localparam logic [7:0] BKT_CODE_RST = 8'd162;

   localparam logic [31:0] LEN_ONE_MAX   = 32'd252;
   localparam logic [31:0] LEN_TWO_MAX   = 32'd508;
   localparam logic [31:0] LEN_THREE_MAX = 32'h0000_ffff;
   localparam logic [31:0] LEN_TWO_BASE  = 32'd253;
   localparam logic [7:0]  LEN_PFX_TWO   = 8'd252;
   localparam logic [7:0]  LEN_PFX_THREE = 8'd253;
   localparam logic [7:0]  LEN_PFX_FIVE  = 8'd254;

   localparam logic [31:0] RUN_MAX = 32'hffff_ffff;

   typedef struct packed {
      logic [7:0] esc_code;
      logic [7:0] mod_code;
      logic [7:0] ins_code;
      logic [7:0] del_code;
      logic [7:0] eql_code;
      logic [7:0] bkt_code;
   } cfg_type;

   typedef enum logic [1:0] {
      TOK_OPC,
      TOK_DATA,
      TOK_LEN
   } tok_kind_type;

   typedef struct packed {
      tok_kind_type kind;
      logic         open;
      logic [31:0]  value;
      logic         last;
   } token_type;

endpackage

@@ hdl/delta_patch_stream_encoder_core.sv @@
// ----------------------------------------------------------------------------
// Delta patch stream encoder core
// Turns a stream of edit operations into an escaped binary patch byte stream.
// ----------------------------------------------------------------------------
// The front end takes one edit operation per cycle as long as the operation
// produces at most one token and the token queue can take it; an operation
// that flushes an equal run or opens an opcode holds the front end while it
// pushes its tokens, up to the larger of four and EQUAL_HOLD_DEPTH + 2
// tokens. The back end emits at most one patch byte per cycle and holds while
// the output stalls, so sustained throughput is at most one output byte per
// cycle, set by the single byte lane of the serialiser. A four-entry token
// queue separates the two. The final byte of a transaction passes from the
// queue through the back end's hold register into the output register.
// Configuration writes take effect at once and are meant for idle periods.
module delta_patch_stream_encoder_core #(
   parameter int unsigned EQUAL_HOLD_DEPTH = dpse_pkg::EQUAL_HOLD_DEPTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [2:0]                         req_mode,
   input  logic [31:0]                        req_length,
   input  logic [7:0]                         req_org_byte,
   input  logic [7:0]                         req_new_byte,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [7:0]                         rsp_out_byte,
   output logic                               rsp_last,
   input  logic                               csr_wr_en,
   input  logic [dpse_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [7:0]                         csr_wdata
);
   import dpse_pkg::*;

   cfg_type   cfg_ff;
   logic      push;
   token_type push_token;
   logic      queue_full;
   logic      pop;
   logic      head_valid;
   token_type head_token;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.esc_code <= ESC_CODE_RST;
         cfg_ff.mod_code <= MOD_CODE_RST;
         cfg_ff.ins_code <= INS_CODE_RST;
         cfg_ff.del_code <= DEL_CODE_RST;
         cfg_ff.eql_code <= EQL_CODE_RST;
         cfg_ff.bkt_code <= BKT_CODE_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ESC: cfg_ff.esc_code <= csr_wdata;
            CSR_MOD: cfg_ff.mod_code <= csr_wdata;
            CSR_INS: cfg_ff.ins_code <= csr_wdata;
            CSR_DEL: cfg_ff.del_code <= csr_wdata;
            CSR_EQL: cfg_ff.eql_code <= csr_wdata;
            CSR_BKT: cfg_ff.bkt_code <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   dpse_front #(
      .EQUAL_HOLD_DEPTH (EQUAL_HOLD_DEPTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_mode     (req_mode),
      .req_length   (req_length),
      .req_org_byte (req_org_byte),
      .req_new_byte (req_new_byte),
      .cfg          (cfg_ff),
      .queue_full   (queue_full),
      .push         (push),
      .push_token   (push_token)
   );

   dpse_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_token (push_token),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_token (head_token)
   );

   dpse_back u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .tok_valid    (head_valid),
      .tok          (head_token),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last)
   );

endmodule

@@ hdl/dpse_front.sv @@
// ----------------------------------------------------------------------------
// Delta patch stream encoder front end
// Accepts edit operations, tracks the open opcode and the equal run, and turns
// each into a short list of tokens, one per cycle while the queue has room.
// ----------------------------------------------------------------------------
module dpse_front #(
   parameter int unsigned EQUAL_HOLD_DEPTH = dpse_pkg::EQUAL_HOLD_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [2:0]          req_mode,
   input  logic [31:0]         req_length,
   input  logic [7:0]          req_org_byte,
   input  logic [7:0]          req_new_byte,
   input  dpse_pkg::cfg_type   cfg,
   input  logic                queue_full,
   output logic                push,
   output dpse_pkg::token_type push_token
);
   import dpse_pkg::*;

   localparam int unsigned NSLOT = EQUAL_HOLD_DEPTH + 3;
   localparam int unsigned SLOTW = $clog2(NSLOT);
   localparam int unsigned IDXW  = (EQUAL_HOLD_DEPTH > 1) ? $clog2(EQUAL_HOLD_DEPTH) : 1;
   localparam logic [SLOTW-1:0] SLOT_PRE_OPC   = '0;
   localparam logic [SLOTW-1:0] SLOT_MAIN_OPC  = SLOTW'(EQUAL_HOLD_DEPTH + 1);
   localparam logic [SLOTW-1:0] SLOT_MAIN_BODY = SLOTW'(EQUAL_HOLD_DEPTH + 2);

   logic              item_valid_ff;
   logic [2:0]        mode_ff;
   logic [31:0]       length_ff;
   logic [7:0]        org_ff;
   logic [7:0]        new_ff;
   logic [NSLOT-1:0]  done_ff;
   logic [2:0]        cur_op_ff;
   logic [31:0]       run_ff;
   logic [7:0]        hold_ff [EQUAL_HOLD_DEPTH];

   logic              mode_ok;
   logic              is_eql;
   logic              is_data_op;
   logic              is_len_op;
   logic              main_active;
   logic              pre_any;
   logic              pre_eql;
   logic              pre_merge;
   logic [2:0]        cur_after;
   logic [NSLOT-1:0]  en;
   logic [NSLOT-1:0]  remaining;
   logic              single;
   logic [SLOTW-1:0]  sel;
   logic [7:0]        hold_val;
   logic [7:0]        main_code;
   logic              finish;
   logic              accept;
   logic [NSLOT-1:0]  done_in;

   always_comb begin
      mode_ok     = (mode_ff <= MODE_EQL);
      is_eql      = (mode_ff == MODE_EQL);
      is_data_op  = (mode_ff == MODE_MOD) || (mode_ff == MODE_INS);
      is_len_op   = (mode_ff == MODE_DEL) || (mode_ff == MODE_BKT);
      main_active = mode_ok && !is_eql;
      pre_any     = main_active && (run_ff != 32'd0);
      pre_eql     = pre_any && ((run_ff > 32'(EQUAL_HOLD_DEPTH)) ||
                    ((cur_op_ff != MODE_MOD) && (mode_ff != MODE_MOD)));
      pre_merge   = pre_any && !pre_eql;
      if (pre_eql) begin
         cur_after = MODE_EQL;
      end else if (pre_merge) begin
         cur_after = MODE_MOD;
      end else begin
         cur_after = cur_op_ff;
      end

      en = '0;
      en[SLOT_PRE_OPC] = pre_eql || (pre_merge && (cur_op_ff != MODE_MOD));
      for (int k = 0; k < EQUAL_HOLD_DEPTH; k++) begin
         en[k + 1] = ((k == 0) && pre_eql) || (pre_merge && (run_ff > 32'(k)));
      end
      en[SLOT_MAIN_OPC]  = (mode_ff == MODE_FLUSH) || is_len_op ||
                           (is_data_op && (cur_after != mode_ff));
      en[SLOT_MAIN_BODY] = is_data_op || is_len_op;

      remaining = item_valid_ff ? (en & ~done_ff) : '0;
      single    = (remaining != '0) && ((remaining & (remaining - 1'b1)) == '0);

      sel = '0;
      for (int i = NSLOT - 1; i >= 0; i--) begin
         if (remaining[i]) begin
            sel = SLOTW'(i);
         end
      end

      hold_val = '0;
      for (int k = 0; k < EQUAL_HOLD_DEPTH; k++) begin
         if (sel == SLOTW'(k + 1)) begin
            hold_val = hold_ff[k];
         end
      end

      case (mode_ff)
         MODE_MOD: main_code = cfg.mod_code;
         MODE_INS: main_code = cfg.ins_code;
         MODE_DEL: main_code = cfg.del_code;
         MODE_BKT: main_code = cfg.bkt_code;
         default:  main_code = '0;
      endcase

      push_token      = '0;
      push_token.last = single;
      if (sel == SLOT_PRE_OPC) begin
         push_token.kind  = TOK_OPC;
         push_token.open  = 1'b1;
         push_token.value = {24'd0, pre_eql ? cfg.eql_code : cfg.mod_code};
      end else if (sel == SLOT_MAIN_OPC) begin
         push_token.kind  = TOK_OPC;
         push_token.open  = (mode_ff != MODE_FLUSH);
         push_token.value = {24'd0, main_code};
      end else if (sel == SLOT_MAIN_BODY) begin
         if (is_data_op) begin
            push_token.kind  = TOK_DATA;
            push_token.value = {24'd0, new_ff};
         end else begin
            push_token.kind  = TOK_LEN;
            push_token.value = length_ff;
         end
      end else if (pre_eql) begin
         push_token.kind  = TOK_LEN;
         push_token.value = run_ff;
      end else begin
         push_token.kind  = TOK_DATA;
         push_token.value = {24'd0, hold_val};
      end

      push      = (remaining != '0) && !queue_full;
      finish    = item_valid_ff && ((remaining == '0) || (single && !queue_full));
      req_stall = item_valid_ff && !finish;
      accept    = req_valid && !req_stall;

      done_in = done_ff;
      if (finish || accept) begin
         done_in = '0;
      end else if (push) begin
         done_in = done_ff | (NSLOT'(1) << sel);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         done_ff       <= '0;
         cur_op_ff     <= MODE_FLUSH;
         run_ff        <= '0;
      end else begin
         done_ff <= done_in;
         if (accept) begin
            item_valid_ff <= 1'b1;
         end else if (finish) begin
            item_valid_ff <= 1'b0;
         end
         if (finish) begin
            if (is_eql) begin
               if (run_ff != RUN_MAX) begin
                  run_ff <= run_ff + 32'd1;
               end
            end else if (mode_ok) begin
               run_ff    <= '0;
               cur_op_ff <= mode_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff   <= req_mode;
         length_ff <= req_length;
         org_ff    <= req_org_byte;
         new_ff    <= req_new_byte;
      end
      if (finish && is_eql && (run_ff < 32'(EQUAL_HOLD_DEPTH))) begin
         hold_ff[run_ff[IDXW-1:0]] <= org_ff;
      end
   end

endmodule

@@ hdl/dpse_queue.sv @@
// ----------------------------------------------------------------------------
// Delta patch stream encoder token queue
// A small first-in first-out buffer that decouples the front end from the
// byte serialiser.
// ----------------------------------------------------------------------------
module dpse_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  dpse_pkg::token_type push_token,
   output logic                full,
   input  logic                pop,
   output logic                head_valid,
   output dpse_pkg::token_type head_token
);
   import dpse_pkg::*;

   localparam int unsigned PTRW = $clog2(QUEUE_DEPTH);

   token_type         store_ff [QUEUE_DEPTH];
   logic [PTRW-1:0]   wr_ptr_ff;
   logic [PTRW-1:0]   rd_ptr_ff;
   logic [PTRW:0]     count_ff;

   assign full       = (count_ff == (PTRW + 1)'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_token = store_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_token;
      end
   end

endmodule

@@ hdl/dpse_back.sv @@
// ----------------------------------------------------------------------------
// Delta patch stream encoder back end
// Expands tokens into patch bytes, applies the escape rules and holds the
// latest byte back until it is known whether it closes its transaction.
// ----------------------------------------------------------------------------
module dpse_back (
   input  logic                clock,
   input  logic                reset,
   input  dpse_pkg::cfg_type   cfg,
   input  logic                tok_valid,
   input  dpse_pkg::token_type tok,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_out_byte,
   output logic                rsp_last
);
   import dpse_pkg::*;

   logic [2:0]  idx_ff;
   logic        pend_ff;
   logic        hold_valid_ff;
   logic [7:0]  hold_byte_ff;
   logic        hold_final_ff;
   logic        rsp_valid_ff;
   logic [7:0]  rsp_byte_ff;
   logic        rsp_last_ff;

   logic [7:0]  lst [5];
   logic [2:0]  cnt;
   logic [2:0]  cnt_m1;
   logic        pend_next;
   logic [7:0]  dval;
   logic        in_range;
   logic [1:0]  n_esc;
   logic        tail;
   logic [31:0] len;
   logic [31:0] len_off;
   logic        out_free;
   logic        back_go;
   logic        step;
   logic        produce;
   logic        tok_done;
   logic        end_step;
   logic        hold_out;
   logic        out_last;

   always_comb begin
      dval      = tok.value[7:0];
      in_range  = (dval >= cfg.bkt_code) && (dval <= cfg.esc_code);
      len       = (tok.value == 32'd0) ? 32'd1 : tok.value;
      len_off   = len - LEN_TWO_BASE;
      n_esc     = '0;
      tail      = 1'b0;
      cnt       = '0;
      cnt_m1    = '0;
      pend_next = pend_ff;
      for (int i = 0; i < 5; i++) begin
         lst[i] = cfg.esc_code;
      end

      case (tok.kind)
         TOK_OPC: begin
            cnt       = {1'b0, pend_ff, 1'b0} + {1'b0, tok.open, 1'b0};
            cnt_m1    = cnt - 3'd1;
            pend_next = 1'b0;
            for (int i = 0; i < 5; i++) begin
               if (tok.open && (3'(i) == cnt_m1)) begin
                  lst[i] = dval;
               end
            end
         end
         TOK_DATA: begin
            n_esc     = pend_ff ? (in_range ? 2'd2 : 2'd1) : 2'd0;
            tail      = (dval != cfg.esc_code);
            cnt       = {1'b0, n_esc} + {2'd0, tail};
            pend_next = !tail;
            for (int i = 0; i < 5; i++) begin
               if (3'(i) >= {1'b0, n_esc}) begin
                  lst[i] = dval;
               end
            end
         end
         TOK_LEN: begin
            if (len <= LEN_ONE_MAX) begin
               cnt    = 3'd1;
               lst[0] = len[7:0] - 8'd1;
            end else if (len <= LEN_TWO_MAX) begin
               cnt    = 3'd2;
               lst[0] = LEN_PFX_TWO;
               lst[1] = len_off[7:0];
            end else if (len <= LEN_THREE_MAX) begin
               cnt    = 3'd3;
               lst[0] = LEN_PFX_THREE;
               lst[1] = len[15:8];
               lst[2] = len[7:0];
            end else begin
               cnt    = 3'd5;
               lst[0] = LEN_PFX_FIVE;
               lst[1] = len[31:24];
               lst[2] = len[23:16];
               lst[3] = len[15:8];
               lst[4] = len[7:0];
            end
         end
         default: begin
            cnt = '0;
         end
      endcase

      out_free = !rsp_valid_ff || !rsp_stall;
      back_go  = !hold_valid_ff || out_free;
      step     = tok_valid && back_go;
      produce  = step && (cnt != 3'd0);
      tok_done = step && ((cnt == 3'd0) || (idx_ff == (cnt - 3'd1)));
      end_step = tok_done && tok.last;
      hold_out = back_go && hold_valid_ff && (produce || end_step || hold_final_ff);
      out_last = hold_final_ff || (end_step && !produce);
      pop      = tok_done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff        <= '0;
         pend_ff       <= 1'b0;
         hold_valid_ff <= 1'b0;
         hold_final_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (tok_done) begin
            idx_ff  <= '0;
            pend_ff <= pend_next;
         end else if (produce) begin
            idx_ff <= idx_ff + 3'd1;
         end
         if (produce) begin
            hold_valid_ff <= 1'b1;
            hold_final_ff <= end_step;
         end else if (hold_out) begin
            hold_valid_ff <= 1'b0;
            hold_final_ff <= 1'b0;
         end
         if (hold_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (produce) begin
         hold_byte_ff <= lst[idx_ff];
      end
      if (hold_out) begin
         rsp_byte_ff <= hold_byte_ff;
         rsp_last_ff <= out_last;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

@@ sim/tb_delta_patch_stream_encoder_core.sv @@
// ----------------------------------------------------------------------------
// Delta patch stream encoder core testbench
// Drives edit operations into the encoder under several opcode settings and
// idling patterns, predicts the escaped patch byte stream with an independent
// encoder model and compares every output transaction with the prediction.
// ----------------------------------------------------------------------------
module tb_delta_patch_stream_encoder_core;
   timeunit 1ns;
   timeprecision 1ps;

   import dpse_pkg::*;

   localparam int unsigned HOLD_DEPTH    = EQUAL_HOLD_DEPTH_DEF;
   localparam int unsigned SETTLE_CYCLES = 32;
   localparam logic [2:0]  MODE_RSVD_A   = 3'd6;
   localparam logic [2:0]  MODE_RSVD_B   = 3'd7;

   typedef struct packed {
      logic [2:0]  mode;
      logic [31:0] length;
      logic [7:0]  org_byte;
      logic [7:0]  new_byte;
   } edit_op_type;

   typedef struct packed {
      logic [7:0] value;
      logic       tail;
   } patch_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_mode = MODE_FLUSH;
   logic [31:0] req_length = '0;
   logic [7:0]  req_org_byte = '0;
   logic [7:0]  req_new_byte = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_last;
   logic        csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_ESC;
   logic [7:0]  csr_wdata = '0;

   edit_op_type    pending_ops[$];
   patch_byte_type patch_expected[$];
   logic [7:0]  item_bytes[$];
   logic        op_taken = 1'b0;
   logic        sender_hold = 1'b0;
   int          send_gap_pct = 0;
   int          rsp_stall_pct = 0;
   int          error_count = 0;

   cfg_type     code_cfg = '{ESC_CODE_RST, MOD_CODE_RST, INS_CODE_RST,
                             DEL_CODE_RST, EQL_CODE_RST, BKT_CODE_RST};
   logic [2:0]  open_op = MODE_FLUSH;
   logic        esc_held = 1'b0;
   logic [31:0] eq_run = '0;
   logic [7:0]  eq_hold [HOLD_DEPTH];

   logic [31:0] len_edges [8] = '{32'd1, 32'd252, 32'd253, 32'd508, 32'd509,
                                  32'h0000_ffff, 32'h0001_0000, 32'hffff_ffff};

   delta_patch_stream_encoder_core dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_mode     (req_mode),
      .req_length   (req_length),
      .req_org_byte (req_org_byte),
      .req_new_byte (req_new_byte),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #2 clock = ~clock;

   // Patch stream predictor.
   function automatic void emit_raw(input logic [7:0] b);
      item_bytes.push_back(b);
   endfunction

   function automatic void emit_opcode(input logic open, input logic [7:0] code);
      if (esc_held) begin
         emit_raw(code_cfg.esc_code);
         emit_raw(code_cfg.esc_code);
         esc_held = 1'b0;
      end
      if (open) begin
         emit_raw(code_cfg.esc_code);
         emit_raw(code);
      end
   endfunction

   function automatic void emit_data(input logic [7:0] v);
      if (esc_held) begin
         esc_held = 1'b0;
         if (v >= code_cfg.bkt_code && v <= code_cfg.esc_code) begin
            emit_raw(code_cfg.esc_code);
         end
         emit_raw(code_cfg.esc_code);
      end
      if (v == code_cfg.esc_code) begin
         esc_held = 1'b1;
      end else begin
         emit_raw(v);
      end
   endfunction

   function automatic void emit_length(input logic [31:0] len);
      logic [31:0] n;
      logic [31:0] rest;
      n = (len == 32'd0) ? 32'd1 : len;
      if (n <= LEN_ONE_MAX) begin
         rest = n - 32'd1;
         emit_raw(rest[7:0]);
      end else if (n <= LEN_TWO_MAX) begin
         rest = n - LEN_TWO_BASE;
         emit_raw(LEN_PFX_TWO);
         emit_raw(rest[7:0]);
      end else if (n <= LEN_THREE_MAX) begin
         emit_raw(LEN_PFX_THREE);
         emit_raw(n[15:8]);
         emit_raw(n[7:0]);
      end else begin
         emit_raw(LEN_PFX_FIVE);
         emit_raw(n[31:24]);
         emit_raw(n[23:16]);
         emit_raw(n[15:8]);
         emit_raw(n[7:0]);
      end
   endfunction

   function automatic void encode_edit(input logic [2:0] mode, input logic [31:0] len,
                                       input logic [7:0] org, input logic [7:0] nb);
      patch_byte_type entry;
      item_bytes.delete();
      if (mode > MODE_EQL) begin
         return;
      end
      if (eq_run != 32'd0 && mode != MODE_EQL) begin
         if (eq_run > HOLD_DEPTH || (open_op != MODE_MOD && mode != MODE_MOD)) begin
            open_op = MODE_EQL;
            emit_opcode(1'b1, code_cfg.eql_code);
            emit_length(eq_run);
         end else begin
            if (open_op != MODE_MOD) begin
               open_op = MODE_MOD;
               emit_opcode(1'b1, code_cfg.mod_code);
            end
            for (int i = 0; i < eq_run; i++) begin
               emit_data(eq_hold[i]);
            end
         end
         eq_run = 32'd0;
      end
      case (mode)
         MODE_FLUSH: begin
            emit_opcode(1'b0, 8'd0);
            open_op = MODE_FLUSH;
         end
         MODE_MOD, MODE_INS: begin
            if (open_op != mode) begin
               open_op = mode;
               emit_opcode(1'b1, (mode == MODE_MOD) ? code_cfg.mod_code : code_cfg.ins_code);
            end
            emit_data(nb);
         end
         MODE_DEL, MODE_BKT: begin
            emit_opcode(1'b1, (mode == MODE_DEL) ? code_cfg.del_code : code_cfg.bkt_code);
            emit_length(len);
            open_op = mode;
         end
         default: begin
            if (eq_run < HOLD_DEPTH) begin
               eq_hold[eq_run] = org;
            end
            if (eq_run != RUN_MAX) begin
               eq_run = eq_run + 32'd1;
            end
         end
      endcase
      foreach (item_bytes[i]) begin
         entry.value = item_bytes[i];
         entry.tail  = (i == item_bytes.size() - 1);
         patch_expected.push_back(entry);
      end
   endfunction

   // Stimulus helpers.
   function automatic void queue_edit(input logic [2:0] mode, input logic [31:0] len,
                                      input logic [7:0] org, input logic [7:0] nb);
      edit_op_type op;
      op.mode     = mode;
      op.length   = len;
      op.org_byte = org;
      op.new_byte = nb;
      pending_ops.push_back(op);
   endfunction

   function automatic logic [7:0] pick_byte();
      logic [7:0] off;
      logic [7:0] v;
      case ($urandom_range(3))
         0: v = code_cfg.esc_code;
         1: begin
            off = $urandom_range(7);
            v = code_cfg.bkt_code - 8'd1 + off;
         end
         default: v = $urandom_range(255);
      endcase
      return v;
   endfunction

   function automatic logic [31:0] pick_length();
      logic [31:0] n;
      case ($urandom_range(9))
         0: n = 32'd0;
         1: n = $urandom_range(252, 1);
         2: n = $urandom_range(508, 253);
         3: n = $urandom_range(32'h0000_ffff, 509);
         4: n = $urandom_range(32'hffff_ffff, 32'h0001_0000);
         5, 6: n = len_edges[$urandom_range(7)];
         default: n = $urandom();
      endcase
      return n;
   endfunction

   function automatic void queue_equal_run(input int count);
      repeat (count) queue_edit(MODE_EQL, $urandom(), pick_byte(), $urandom_range(255));
   endfunction

   function automatic void queue_data_run(input logic [2:0] mode, input int count);
      repeat (count) queue_edit(mode, $urandom(), $urandom_range(255), pick_byte());
   endfunction

   function automatic void queue_random_edits(input int count);
      int made;
      int pick;
      int run;
      made = 0;
      while (made < count) begin
         pick = $urandom_range(99);
         run  = $urandom_range(6, 1);
         if (pick < 22) begin
            queue_data_run(MODE_MOD, run);
            made += run;
         end else if (pick < 34) begin
            queue_data_run(MODE_INS, run);
            made += run;
         end else if (pick < 50) begin
            queue_data_run(MODE_MOD, 1);
            run = $urandom_range(HOLD_DEPTH, 1);
            queue_equal_run(run);
            queue_data_run(MODE_MOD, 1);
            made += run + 2;
         end else if (pick < 62) begin
            run = $urandom_range(9, 1);
            queue_equal_run(run);
            made += run;
         end else if (pick < 74) begin
            queue_edit(MODE_DEL, pick_length(), $urandom_range(255), $urandom_range(255));
            made++;
         end else if (pick < 84) begin
            queue_edit(MODE_BKT, pick_length(), $urandom_range(255), $urandom_range(255));
            made++;
         end else if (pick < 93) begin
            queue_edit(MODE_FLUSH, $urandom(), $urandom_range(255), $urandom_range(255));
            made++;
         end else begin
            queue_edit(pick[0] ? MODE_RSVD_A : MODE_RSVD_B, $urandom(),
                       $urandom_range(255), $urandom_range(255));
         end
      end
   endfunction

   function automatic cfg_type random_codes();
      cfg_type c;
      c.esc_code = $urandom_range(255);
      c.mod_code = $urandom_range(255);
      c.ins_code = $urandom_range(255);
      c.del_code = $urandom_range(255);
      c.eql_code = $urandom_range(255);
      c.bkt_code = $urandom_range(255);
      return c;
   endfunction

   task automatic load_codes(input cfg_type codes);
      logic [7:0]             vals [6];
      logic [CSR_INDEX_W-1:0] idxs [6];
      vals = '{codes.esc_code, codes.mod_code, codes.ins_code,
               codes.del_code, codes.eql_code, codes.bkt_code};
      idxs = '{CSR_ESC, CSR_MOD, CSR_INS, CSR_DEL, CSR_EQL, CSR_BKT};
      for (int i = 0; i < 6; i++) begin
         @(negedge clock);
         csr_wr_en <= 1'b1;
         csr_index <= idxs[i];
         csr_wdata <= vals[i];
      end
      @(negedge clock);
      csr_wr_en <= 1'b0;
      code_cfg = codes;
   endtask

   task automatic wait_drained();
      while (pending_ops.size() != 0 || req_valid || patch_expected.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Input driver.
   always @(negedge clock) begin : drive_edits
      edit_op_type op;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || op_taken) begin
         if (pending_ops.size() != 0 && !sender_hold && $urandom_range(99) >= send_gap_pct) begin
            op = pending_ops.pop_front();
            req_valid    <= 1'b1;
            req_mode     <= op.mode;
            req_length   <= op.length;
            req_org_byte <= op.org_byte;
            req_new_byte <= op.new_byte;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   // Monitor and checker.
   always @(posedge clock) begin : check_patch
      patch_byte_type want;
      if (reset) begin
         op_taken <= 1'b0;
      end else begin
         op_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            encode_edit(req_mode, req_length, req_org_byte, req_new_byte);
         end
         if (rsp_valid && !rsp_stall) begin
            if (patch_expected.size() == 0) begin
               $error("unexpected output transaction: out_byte %0d, last %0d",
                      rsp_out_byte, rsp_last);
               error_count++;
            end else begin
               want = patch_expected.pop_front();
               if (rsp_out_byte !== want.value) begin
                  $error("out_byte mismatch: expected %0d, actual %0d", want.value, rsp_out_byte);
                  error_count++;
               end
               if (rsp_last !== want.tail) begin
                  $error("last mismatch: expected %0d, actual %0d", want.tail, rsp_last);
                  error_count++;
               end
            end
         end
      end
   end

   initial begin
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      cfg_type codes;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reserved modes, escape handling, merged and separate equal runs, length forms.
      queue_edit(MODE_RSVD_A, 32'hffff_ffff, 8'hff, 8'hff);
      queue_edit(MODE_RSVD_B, 32'd0, 8'h00, 8'h00);
      queue_edit(MODE_MOD, 32'd0, 8'h00, 8'h00);
      queue_edit(MODE_MOD, 32'd0, 8'h00, ESC_CODE_RST);
      queue_edit(MODE_MOD, 32'd0, 8'h00, BKT_CODE_RST);
      queue_edit(MODE_INS, 32'd0, 8'h00, ESC_CODE_RST);
      queue_edit(MODE_FLUSH, 32'd0, 8'h00, 8'h00);
      queue_edit(MODE_EQL, 32'd0, 8'h00, 8'h00);
      queue_edit(MODE_EQL, 32'd0, ESC_CODE_RST, 8'h00);
      queue_edit(MODE_MOD, 32'd0, 8'h00, BKT_CODE_RST);
      repeat (5) queue_edit(MODE_EQL, 32'd0, 8'hff, 8'h00);
      queue_edit(MODE_BKT, 32'd0, 8'h00, 8'h00);
      foreach (len_edges[i]) begin
         queue_edit(i[0] ? MODE_BKT : MODE_DEL, len_edges[i], 8'h00, 8'h00);
      end
      queue_random_edits(35);
      wait_drained();

      // Whole byte range reserved, sender idling.
      codes = '{8'd255, 8'd254, 8'd253, 8'd252, 8'd251, 8'd0};
      load_codes(codes);
      send_gap_pct = 48;
      queue_random_edits(35);
      wait_drained();

      // Empty reserved range, receiver stalling.
      codes = random_codes();
      codes.esc_code = 8'd0;
      codes.bkt_code = 8'd255;
      load_codes(codes);
      send_gap_pct  = 0;
      rsp_stall_pct = 48;
      queue_random_edits(35);
      wait_drained();

      // Random codes, both sides idling, with a pause until the output has caught up.
      load_codes(random_codes());
      send_gap_pct  = 12;
      rsp_stall_pct = 12;
      queue_random_edits(35);
      while (pending_ops.size() > 20) @(posedge clock);
      sender_hold = 1'b1;
      while (req_valid || patch_expected.size() != 0) @(posedge clock);
      sender_hold = 1'b0;
      wait_drained();

      // Back to the reset codes at full rate.
      codes = '{ESC_CODE_RST, MOD_CODE_RST, INS_CODE_RST,
                DEL_CODE_RST, EQL_CODE_RST, BKT_CODE_RST};
      load_codes(codes);
      send_gap_pct  = 0;
      rsp_stall_pct = 0;
      queue_random_edits(35);
      wait_drained();

      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
